/* rtl/tfn_pkg.sv */
// tfn_pkg: widths, constants and types shared by the triangle face normal block
// used by tfn_norm and triangle_face_normal; depends on nothing else
package tfn_pkg;

	// field widths
	localparam int COORD_W = 16;
	localparam int NORM_W = 16;
	localparam int FRAC_BITS = 14;
	localparam int CFG_W = 16;

	// arithmetic widths along the datapath
	localparam int EDGE_W = COORD_W + 1;
	localparam int PROD_W = 2 * EDGE_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int REDUCE_BITS = 20;
	localparam int LEN_W = 6;
	localparam int SHIFT_W = 4;
	localparam int R2_W = 2 * REDUCE_BITS;
	localparam int SUM_W = R2_W + 2;
	localparam int SCALE_W = FRAC_BITS + 1;

	// quotient of r^2 * 2^(2F+2) / sum is at most 2^(2F+2)
	localparam int QUO_W = 2 * FRAC_BITS + 3;
	localparam int DIV_STAGES = QUO_W;
	localparam int SQRT_IN_W = 2 * ((QUO_W + 1) / 2);
	localparam int SQRT_STAGES = SQRT_IN_W / 2;
	localparam int ROOT_W = SQRT_STAGES;
	localparam int SQRT_REM_W = ROOT_W + 2;
	localparam int NORM_LAT = DIV_STAGES + SQRT_STAGES;

	// small triangles: all components below 2^SMALL_W go through the limit check
	localparam int SMALL_W = 8;
	localparam int SMALL_SUM_W = 2 * SMALL_W + 2;

	localparam logic [CFG_W-1:0] MIN_LEN_SQ_RESET = CFG_W'(43);
	localparam logic [NORM_W-1:0] UNIT_ONE = NORM_W'(1) << FRAC_BITS;

	// per request control that rides alongside the normalize pipeline
	typedef struct packed {
		logic       valid;
		logic       degen;
		logic [2:0] neg;
		logic       last;
	} side_t;

endpackage

/* rtl/tfn_norm.sv */
// tfn_norm: pipelined scale factor round(r * 2^F / sqrt(sum)) for one component
// restoring divider followed by a digit-by-digit square root; uses tfn_pkg
module tfn_norm (
	input  logic                             clk,
	input  logic                             en,
	input  logic [tfn_pkg::R2_W-1:0]         r2,
	input  logic [tfn_pkg::SUM_W-1:0]        sum,
	output logic [tfn_pkg::SCALE_W-1:0]      scale
);

	localparam int DS = tfn_pkg::DIV_STAGES;
	localparam int QW = tfn_pkg::QUO_W;
	localparam int SW = tfn_pkg::SUM_W;
	localparam int SS = tfn_pkg::SQRT_STAGES;
	localparam int RW = tfn_pkg::ROOT_W;
	localparam int XW = tfn_pkg::SQRT_REM_W;
	localparam int IW = tfn_pkg::SQRT_IN_W;
	localparam int LOW_ZERO = QW - 1;

	// divider stages: remainder, pending dividend bits, divisor, quotient
	logic [SW-1:0] rem_s [0:DS-1];
	logic [QW-1:0] low_s [0:DS-1];
	logic [SW-1:0] div_s [0:DS-1];
	logic [QW-1:0] quo_s [0:DS-1];

	// square root stages
	logic [XW-1:0] srem_s [0:SS-1];
	logic [IW-1:0] sval_s [0:SS-1];
	logic [RW-1:0] root_s [0:SS-1];

	logic [RW:0] round_sum;

	genvar k;
	generate
		for (k = 0; k < DS; k++) begin : g_div
			logic [SW-1:0] rem_in;
			logic [QW-1:0] low_in;
			logic [SW-1:0] div_in;
			logic [QW-1:0] quo_in;
			logic [SW:0]   trial;
			logic          ge;

			if (k == 0) begin : g_first
				// dividend is r2 << (QW-1); start with its top bits
				assign rem_in = SW'(r2 >> 1);
				assign low_in = {r2[0], {LOW_ZERO{1'b0}}};
				assign div_in = sum;
				assign quo_in = '0;
			end else begin : g_next
				assign rem_in = rem_s[k-1];
				assign low_in = low_s[k-1];
				assign div_in = div_s[k-1];
				assign quo_in = quo_s[k-1];
			end

			// one quotient bit per stage
			assign trial = {rem_in, low_in[QW-1]};
			assign ge = (trial >= {1'b0, div_in});

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? SW'(trial - {1'b0, div_in}) : trial[SW-1:0];
					low_s[k] <= {low_in[QW-2:0], 1'b0};
					div_s[k] <= div_in;
					quo_s[k] <= {quo_in[QW-2:0], ge};
				end
			end
		end

		for (k = 0; k < SS; k++) begin : g_sqrt
			logic [XW-1:0] rem_in;
			logic [IW-1:0] val_in;
			logic [RW-1:0] root_in;
			logic [XW+1:0] cur;
			logic [XW+1:0] trial;
			logic          ge;

			if (k == 0) begin : g_first
				assign rem_in = '0;
				assign val_in = IW'(quo_s[DS-1]);
				assign root_in = '0;
			end else begin : g_next
				assign rem_in = srem_s[k-1];
				assign val_in = sval_s[k-1];
				assign root_in = root_s[k-1];
			end

			// one root bit per stage
			assign cur = {rem_in, val_in[IW-1 -: 2]};
			assign trial = (XW+2)'({root_in, 2'b01});
			assign ge = (cur >= trial);

			always_ff @(posedge clk) begin
				if (en) begin
					srem_s[k] <= ge ? XW'(cur - trial) : cur[XW-1:0];
					sval_s[k] <= {val_in[IW-3:0], 2'b00};
					root_s[k] <= {root_in[RW-2:0], ge};
				end
			end
		end
	endgenerate

	// largest odd o with o <= root gives (root + 1) / 2
	assign round_sum = {1'b0, root_s[SS-1]} + (RW+1)'(1);
	assign scale = round_sum[tfn_pkg::SCALE_W:1];

endmodule

/* rtl/triangle_face_normal.sv */
// triangle_face_normal: unit triangle face normal, one request per unstalled cycle
// top level; uses tfn_pkg and tfn_norm
//
// input channel s_*: one triangle per request, vertices a, b, c in signed Q8.8,
//   s_tlast marks the final triangle of a mesh
// output channel m_*: one unit normal in signed Q1.14 per triangle, m_tuser is
//   the degenerate flag (default normal 0, 1.0, 0 given), m_tlast copies s_tlast
// cfg_we / cfg_wdata: degeneracy limit on the squared cross product length,
//   write only while no request is in flight
// pipeline: cross product and reduction stages, 31 divider stages, 16 square root
//   stages, one output register
// throughput: one triangle per unstalled cycle; every stage is a register stage
// stall: the whole pipeline holds while an output request waits, and input
//   requests are taken whenever the output register is empty or being taken
// reset: all valid bits clear, the limit returns to 43
module triangle_face_normal (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// ax, ay, az, bx, by, bz, cx, cy, cz (16 bits each)
	input  logic [9*tfn_pkg::COORD_W-1:0]    s_tdata,
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// normal_x, normal_y, normal_z (16 bits each)
	output logic [3*tfn_pkg::NORM_W-1:0]     m_tdata,
	// degenerate
	output logic                             m_tuser,
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [tfn_pkg::CFG_W-1:0]        cfg_wdata
);

	localparam int CW = tfn_pkg::COORD_W;
	localparam int EW = tfn_pkg::EDGE_W;
	localparam int PW = tfn_pkg::PROD_W;
	localparam int XW = tfn_pkg::CROSS_W;
	localparam int NW = tfn_pkg::NORM_W;
	localparam int RB = tfn_pkg::REDUCE_BITS;
	localparam int NL = tfn_pkg::NORM_LAT;

	logic en;
	logic [tfn_pkg::CFG_W-1:0] min_len_sq_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic l_s1, l_s2, l_s3, l_s4, l_s5, l_s6, l_s7, l_s8;
	logic [2:0] neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;
	logic degen_s5, degen_s6, degen_s7, degen_s8;

	logic signed [EW-1:0] e1_s1 [0:2];
	logic signed [EW-1:0] e2_s1 [0:2];
	logic signed [PW-1:0] p_s2 [0:5];
	logic signed [XW-1:0] n_s3 [0:2];
	logic [XW-1:0] mag_s4 [0:2];
	logic [XW-1:0] mag_s5 [0:2];
	logic [tfn_pkg::SHIFT_W-1:0] sh_s5;
	logic [RB-1:0] r_s6 [0:2];
	logic [tfn_pkg::R2_W-1:0] r2_s7 [0:2];
	logic [tfn_pkg::R2_W-1:0] r2_s8 [0:2];
	logic [tfn_pkg::SUM_W-1:0] sum_s8;

	tfn_pkg::side_t side_s [0:NL-1];
	logic [tfn_pkg::SCALE_W-1:0] scale [0:2];

	logic [NW-1:0] nx_q, ny_q, nz_q;
	logic degen_q, last_q, valid_q;

	// pipeline moves unless a finished request waits
	assign en = !valid_q || m_tready;
	assign s_tready = en;

	// degeneracy limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_sq_q <= tfn_pkg::MIN_LEN_SQ_RESET;
		end else if (cfg_we) begin
			min_len_sq_q <= cfg_wdata;
		end
	end

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// stage 1: edge vectors b - a and c - a
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= EW'($signed(s_tdata[(3+i)*CW +: CW]))
					- EW'($signed(s_tdata[i*CW +: CW]));
				e2_s1[i] <= EW'($signed(s_tdata[(6+i)*CW +: CW]))
					- EW'($signed(s_tdata[i*CW +: CW]));
			end
			l_s1 <= s_tlast;
		end
	end

	// stage 2: the six cross products
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= PW'(e1_s1[1] * e2_s1[2]);
			p_s2[1] <= PW'(e1_s1[2] * e2_s1[1]);
			p_s2[2] <= PW'(e1_s1[2] * e2_s1[0]);
			p_s2[3] <= PW'(e1_s1[0] * e2_s1[2]);
			p_s2[4] <= PW'(e1_s1[0] * e2_s1[1]);
			p_s2[5] <= PW'(e1_s1[1] * e2_s1[0]);
			l_s2 <= l_s1;
		end
	end

	// stage 3: cross product components
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				n_s3[i] <= XW'(p_s2[2*i]) - XW'(p_s2[2*i+1]);
			end
			l_s3 <= l_s2;
		end
	end

	// stage 4: sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= n_s3[i][XW-1];
				mag_s4[i] <= n_s3[i][XW-1] ? XW'(-n_s3[i]) : XW'(n_s3[i]);
			end
			l_s4 <= l_s3;
		end
	end

	// stage 5: degeneracy check and reduction shift
	logic [XW-1:0] mag_or;
	logic [tfn_pkg::LEN_W-1:0] len;
	logic all_small;
	logic [tfn_pkg::SMALL_SUM_W-1:0] small_sum;

	always_comb begin
		mag_or = mag_s4[0] | mag_s4[1] | mag_s4[2];
		len = '0;
		for (int i = 0; i < XW; i++) begin
			if (mag_or[i]) len = tfn_pkg::LEN_W'(i + 1);
		end
		all_small = (mag_or[XW-1:tfn_pkg::SMALL_W] == '0);
		small_sum = '0;
		for (int i = 0; i < 3; i++) begin
			small_sum = small_sum + tfn_pkg::SMALL_SUM_W'(
				mag_s4[i][tfn_pkg::SMALL_W-1:0] * mag_s4[i][tfn_pkg::SMALL_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s5 <= mag_s4;
			neg_s5 <= neg_s4;
			degen_s5 <= all_small
				&& (small_sum <= tfn_pkg::SMALL_SUM_W'(min_len_sq_q));
			sh_s5 <= (len > tfn_pkg::LEN_W'(RB))
				? tfn_pkg::SHIFT_W'(len - tfn_pkg::LEN_W'(RB)) : '0;
			l_s5 <= l_s4;
		end
	end

	// stage 6: reduce to the normalize width
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				r_s6[i] <= RB'(mag_s5[i] >> sh_s5);
			end
			neg_s6 <= neg_s5;
			degen_s6 <= degen_s5;
			l_s6 <= l_s5;
		end
	end

	// stage 7: squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				r2_s7[i] <= tfn_pkg::R2_W'(r_s6[i] * r_s6[i]);
			end
			neg_s7 <= neg_s6;
			degen_s7 <= degen_s6;
			l_s7 <= l_s6;
		end
	end

	// stage 8: squared length
	always_ff @(posedge clk) begin
		if (en) begin
			r2_s8 <= r2_s7;
			sum_s8 <= tfn_pkg::SUM_W'(r2_s7[0]) + tfn_pkg::SUM_W'(r2_s7[1])
				+ tfn_pkg::SUM_W'(r2_s7[2]);
			neg_s8 <= neg_s7;
			degen_s8 <= degen_s7;
			l_s8 <= l_s7;
		end
	end

	// per component scale factors
	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : g_norm
			tfn_norm u_norm (
				.clk   (clk),
				.en    (en),
				.r2    (r2_s8[g]),
				.sum   (sum_s8),
				.scale (scale[g])
			);
		end
	endgenerate

	// control alongside the normalize stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NL; i++) begin
				side_s[i] <= '0;
			end
		end else if (en) begin
			side_s[0] <= '{valid: v_s8, degen: degen_s8, neg: neg_s8, last: l_s8};
			for (int i = 1; i < NL; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= side_s[NL-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_q <= side_s[NL-1].degen;
			last_q <= side_s[NL-1].last;
			if (side_s[NL-1].degen) begin
				nx_q <= '0;
				ny_q <= tfn_pkg::UNIT_ONE;
				nz_q <= '0;
			end else begin
				nx_q <= side_s[NL-1].neg[0] ? NW'(-NW'(scale[0])) : NW'(scale[0]);
				ny_q <= side_s[NL-1].neg[1] ? NW'(-NW'(scale[1])) : NW'(scale[1]);
				nz_q <= side_s[NL-1].neg[2] ? NW'(-NW'(scale[2])) : NW'(scale[2]);
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {nz_q, ny_q, nx_q};
	assign m_tuser = degen_q;
	assign m_tlast = last_q;

`ifndef ASSERT_OFF
	// a degenerate result always carries the default up normal
	a_degen_default: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> nx_q == '0 && nz_q == '0 && ny_q == tfn_pkg::UNIT_ONE)
		else $error("degenerate result without default normal");

	// the x and z components of a normal never exceed one in magnitude
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> $signed(nx_q) <= $signed(tfn_pkg::UNIT_ONE)
			&& $signed(nx_q) >= -$signed(tfn_pkg::UNIT_ONE)
			&& $signed(nz_q) <= $signed(tfn_pkg::UNIT_ONE)
			&& $signed(nz_q) >= -$signed(tfn_pkg::UNIT_ONE))
		else $error("normal component out of range");

	// an empty output register never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");
`endif

endmodule

/* dv/tb_triangle_face_normal.sv */
// tb_triangle_face_normal: self-checking testbench for the triangle face normal block
// depends on tfn_pkg and triangle_face_normal; drives triangles, predicts unit normals
`timescale 1ns / 100ps

module tb_triangle_face_normal;

	typedef struct {
		logic [tfn_pkg::NORM_W-1:0] nx;
		logic [tfn_pkg::NORM_W-1:0] ny;
		logic [tfn_pkg::NORM_W-1:0] nz;
		logic                       degen;
		logic                       last;
	} normal_t;

	localparam int LATENCY = 56;
	localparam int WATCHDOG_LIMIT = 20000;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                s_tvalid = 1'b0;
	logic                                s_tready;
	logic [9*tfn_pkg::COORD_W-1:0]       s_tdata = '0;
	logic                                s_tlast = 1'b0;
	logic                                m_tvalid;
	logic                                m_tready = 1'b0;
	logic [3*tfn_pkg::NORM_W-1:0]        m_tdata;
	logic                                m_tuser;
	logic                                m_tlast;
	logic                                cfg_we = 1'b0;
	logic [tfn_pkg::CFG_W-1:0]           cfg_wdata = '0;

	logic [tfn_pkg::CFG_W-1:0] min_len_sq = tfn_pkg::MIN_LEN_SQ_RESET;
	normal_t          expected_normals[$];
	int               fail_count = 0;
	int               idle_cycles = 0;
	bit               rx_hold_req = 1'b0;
	int               gap_mode = 1;

	triangle_face_normal uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	// exact rounded r * 2^F / sqrt(sum) by bitwise search
	function automatic logic [63:0] scale_component(logic [63:0] r, logic [63:0] sum);
		logic [63:0]  q;
		logic [63:0]  t;
		logic [63:0]  o;
		logic [127:0] rhs;
		logic [127:0] lhs;
		q = 0;
		rhs = 128'(r * r) << (2 * tfn_pkg::FRAC_BITS + 2);
		for (int b = tfn_pkg::FRAC_BITS; b >= 0; b--) begin
			t = q | (64'd1 << b);
			o = 2 * t - 1;
			lhs = 128'(o * o) * 128'(sum);
			if (t <= (64'd1 << tfn_pkg::FRAC_BITS) && lhs <= rhs)
				q = t;
		end
		return q;
	endfunction

	// predicted normal of one triangle
	function automatic normal_t predict_normal(logic [9*tfn_pkg::COORD_W-1:0] tri_data,
		logic last);
		longint    v[9];
		longint    e1[3];
		longint    e2[3];
		logic signed [67:0] n[3];
		logic [67:0] m[3];
		logic [63:0] r[3];
		logic [63:0] sum;
		logic [63:0] q;
		logic [63:0] s2;
		logic [15:0] res[3];
		int        len;
		int        sh;
		bit        degen;
		normal_t   o;
		for (int i = 0; i < 9; i++)
			v[i] = longint'($signed(tri_data[i*tfn_pkg::COORD_W +: tfn_pkg::COORD_W]));
		for (int i = 0; i < 3; i++) begin
			e1[i] = v[3+i] - v[i];
			e2[i] = v[6+i] - v[i];
		end
		n[0] = 68'(e1[1]) * 68'(e2[2]) - 68'(e1[2]) * 68'(e2[1]);
		n[1] = 68'(e1[2]) * 68'(e2[0]) - 68'(e1[0]) * 68'(e2[2]);
		n[2] = 68'(e1[0]) * 68'(e2[1]) - 68'(e1[1]) * 68'(e2[0]);
		degen = 1'b1;
		len = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = n[i] < 0 ? -n[i] : n[i];
			if (m[i] >= 256) degen = 1'b0;
			for (int b = 0; b < 68; b++)
				if (m[i][b] && b + 1 > len) len = b + 1;
		end
		if (degen) begin
			s2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
			degen = s2 <= 64'(min_len_sq);
		end
		if (degen) begin
			res[0] = 0;
			res[1] = tfn_pkg::UNIT_ONE;
			res[2] = 0;
		end else begin
			sh = len > tfn_pkg::REDUCE_BITS ? len - tfn_pkg::REDUCE_BITS : 0;
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				r[i] = 64'(m[i] >> sh);
				sum += r[i] * r[i];
			end
			for (int i = 0; i < 3; i++) begin
				q = scale_component(r[i], sum);
				res[i] = n[i] < 0 ? 16'(-q) : 16'(q);
			end
		end
		o.nx = res[0];
		o.ny = res[1];
		o.nz = res[2];
		o.degen = degen;
		o.last = last;
		return o;
	endfunction

	function automatic int random_gap();
		if (gap_mode == 0) return 0;
		if ($urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// send one triangle request and record its expected normal
	task automatic send_triangle(logic [9*tfn_pkg::COORD_W-1:0] tri_data, logic last);
		int gap;
		gap = random_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= tri_data;
		s_tlast <= last;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_normals.push_back(predict_normal(tri_data, last));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_normals.size() != 0) @(negedge clk);
		repeat (LATENCY + 8) @(negedge clk);
	endtask

	task automatic write_limit(logic [tfn_pkg::CFG_W-1:0] value);
		wait_drained();
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		min_len_sq = value;
	endtask

	function automatic logic [9*tfn_pkg::COORD_W-1:0] pack_tri(longint c[9]);
		logic [9*tfn_pkg::COORD_W-1:0] t;
		for (int i = 0; i < 9; i++)
			t[i*tfn_pkg::COORD_W +: tfn_pkg::COORD_W] = tfn_pkg::COORD_W'(c[i]);
		return t;
	endfunction

	// random triangle, sized by class to hit degenerate, small and full range
	function automatic logic [9*tfn_pkg::COORD_W-1:0] random_triangle();
		longint c[9];
		int     k;
		int     span;
		k = $urandom_range(0, 9);
		span = k < 2 ? 1 : (k < 4 ? 16 : (k < 6 ? 600 : 0));
		for (int i = 0; i < 9; i++) c[i] = longint'($signed(16'($urandom)));
		if (span != 0)
			for (int i = 3; i < 9; i++)
				c[i] = c[i % 3] + longint'($urandom_range(0, 2 * span)) - span;
		if (k == 9)
			for (int i = 0; i < 9; i++) c[i] = $urandom_range(0, 1) ? 32767 : -32768;
		return pack_tri(c);
	endfunction

	task automatic test_directed();
		longint c[9];
		send_triangle('0, 1'b0);
		c = '{0, 0, 0, 256, 0, 0, 0, 256, 0};
		send_triangle(pack_tri(c), 1'b0);
		c = '{0, 0, 0, 0, 0, 256, 256, 0, 0};
		send_triangle(pack_tri(c), 1'b1);
		c = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
		send_triangle(pack_tri(c), 1'b0);
		c = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
		send_triangle(pack_tri(c), 1'b1);
		c = '{-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, -32768};
		send_triangle(pack_tri(c), 1'b0);
		// tiny cross products near the limit
		c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
		send_triangle(pack_tri(c), 1'b0);
		c = '{0, 0, 0, 6, 0, 0, 0, 1, 0};
		send_triangle(pack_tri(c), 1'b0);
		c = '{0, 0, 0, 7, 0, 0, 0, 1, 0};
		send_triangle(pack_tri(c), 1'b0);
		c = '{0, 0, 0, 15, 0, 0, 0, 17, 0};
		send_triangle(pack_tri(c), 1'b0);
		c = '{0, 0, 0, 16, 0, 0, 0, 16, 0};
		send_triangle(pack_tri(c), 1'b0);
		// collinear and negative components
		c = '{100, 100, 100, 200, 200, 200, 300, 300, 300};
		send_triangle(pack_tri(c), 1'b0);
		c = '{0, 0, 0, 0, 256, 0, 256, 0, 0};
		send_triangle(pack_tri(c), 1'b0);
		c = '{5, -3, 7, -20, 11, 4, 9, 9, -30};
		send_triangle(pack_tri(c), 1'b1);
	endtask

	task automatic test_limit_settings();
		logic [tfn_pkg::CFG_W-1:0] limits[4];
		limits = '{16'd0, 16'hFFFF, 16'd1, 16'd43};
		foreach (limits[j]) begin
			write_limit(limits[j]);
			for (int i = 0; i < 60; i++) begin
				longint c[9];
				for (int t = 0; t < 9; t++) c[t] = $urandom_range(0, 300) - 150;
				for (int t = 3; t < 9; t++) c[t] = c[t % 3] + $urandom_range(0, 30) - 15;
				send_triangle(pack_tri(c), 1'($urandom));
			end
		end
	endtask

	task automatic test_random(int count);
		write_limit(16'($urandom));
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) write_limit(16'($urandom_range(0, 300)));
			send_triangle(random_triangle(), 1'($urandom));
		end
	endtask

	// back pressure: receiver holds while the sender keeps going, then a full drain
	task automatic test_backpressure();
		gap_mode = 0;
		rx_hold_req = 1'b1;
		for (int i = 0; i < 150; i++) send_triangle(random_triangle(), 1'($urandom));
		gap_mode = 1;
		wait_drained();
		for (int i = 0; i < 100; i++) send_triangle(random_triangle(), 1'($urandom));
		gap_mode = 0;
		for (int i = 0; i < 100; i++) send_triangle(random_triangle(), 1'($urandom));
		gap_mode = 1;
	endtask

	// receiver ready pattern, with one long hold-off on request
	initial begin
		int hold;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_tready <= 1'b0;
				hold = 300;
				repeat (hold) @(negedge clk);
			end
			if (gap_mode == 0) m_tready <= 1'b1;
			else if ($urandom_range(0, 29) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(5, 40)) @(negedge clk);
				m_tready <= 1'b1;
			end else m_tready <= $urandom_range(0, 3) != 0;
		end
	end

	// result checker
	always @(posedge clk) begin
		normal_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_normals.size() == 0) begin
				$error("unexpected normal request %h", m_tdata);
				fail_count++;
			end else begin
				e = expected_normals.pop_front();
				if (m_tdata[0 +: tfn_pkg::NORM_W] !== e.nx) begin
					$error("normal_x expected %h actual %h", e.nx,
						m_tdata[0 +: tfn_pkg::NORM_W]);
					fail_count++;
				end
				if (m_tdata[tfn_pkg::NORM_W +: tfn_pkg::NORM_W] !== e.ny) begin
					$error("normal_y expected %h actual %h", e.ny,
						m_tdata[tfn_pkg::NORM_W +: tfn_pkg::NORM_W]);
					fail_count++;
				end
				if (m_tdata[2*tfn_pkg::NORM_W +: tfn_pkg::NORM_W] !== e.nz) begin
					$error("normal_z expected %h actual %h", e.nz,
						m_tdata[2*tfn_pkg::NORM_W +: tfn_pkg::NORM_W]);
					fail_count++;
				end
				if (m_tuser !== e.degen) begin
					$error("degenerate expected %b actual %b", e.degen, m_tuser);
					fail_count++;
				end
				if (m_tlast !== e.last) begin
					$error("last_normal expected %b actual %b", e.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted request
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_limit_settings();
		test_backpressure();
		test_random(1100);
		wait_drained();
		if (fail_count == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
rtl/tfn_pkg.sv
rtl/tfn_norm.sv
rtl/triangle_face_normal.sv
dv/tb_triangle_face_normal.sv
